// ===== hdl/tdpc_pkg.sv =====
// shared types, constants and widths for the tilt pad with calibration
package tdpc_pkg;

	// field widths
	localparam int ACCEL_W     = 10;
	localparam int THR_W       = 9;
	localparam int TOL_W       = 12;
	localparam int OFFSET_W    = 8;
	localparam int SUM_W       = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 12;
	localparam int S_TDATA_W   = 32;
	localparam int M_TDATA_W   = 40;

	// default number of stable face-up samples averaged
	localparam int CAL_SAMPLES_DEF = 32;

	// register reset values
	localparam logic [THR_W-1:0]    ON_THR_RST  = THR_W'(80);
	localparam logic [THR_W-1:0]    OFF_THR_RST = THR_W'(30);
	localparam logic [THR_W-1:0]    ONE_G_RST   = THR_W'(256);
	localparam logic [TOL_W-1:0]    TOL_RST     = TOL_W'(16);
	localparam logic [OFFSET_W-1:0] OFFSET_RST  = '0;

	// pad axis direction, two's complement coding
	typedef enum logic [1:0] {
		DIR_NONE = 2'b00,
		DIR_POS  = 2'b01,
		DIR_NEG  = 2'b11
	} dir_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ON_THR   = 3'd0,
		REG_OFF_THR  = 3'd1,
		REG_ONE_G    = 3'd2,
		REG_TOL      = 3'd3,
		REG_OFFSET_X = 3'd4,
		REG_OFFSET_Y = 3'd5,
		REG_OFFSET_Z = 3'd6
	} cfg_idx_t;

	// configuration register file contents
	typedef struct packed {
		logic [THR_W-1:0]    on_thr;
		logic [THR_W-1:0]    off_thr;
		logic [THR_W-1:0]    one_g;
		logic [TOL_W-1:0]    tol;
		logic [OFFSET_W-1:0] offset_x;
		logic [OFFSET_W-1:0] offset_y;
		logic [OFFSET_W-1:0] offset_z;
	} cfg_t;

	// calibrator status for the item in flight
	typedef struct packed {
		logic                calibrated;
		logic                ready;
		logic [OFFSET_W-1:0] offset_x;
		logic [OFFSET_W-1:0] offset_y;
		logic [OFFSET_W-1:0] offset_z;
	} cal_res_t;

	// pad axis result for the item in flight
	typedef struct packed {
		dir_t press;
		dir_t held;
	} axis_res_t;

endpackage

// ===== hdl/tdpc_axis.sv =====
// one three-state pad axis with hysteresis
module tdpc_axis (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               update,
	input  logic signed [tdpc_pkg::ACCEL_W-1:0] tilt,
	input  logic [tdpc_pkg::THR_W-1:0]         on_thr,
	input  logic [tdpc_pkg::THR_W-1:0]         off_thr,
	output tdpc_pkg::axis_res_t                res
);
	import tdpc_pkg::*;

	dir_t dir_q;
	dir_t dir_nxt;
	logic signed [ACCEL_W:0] tilt_e;
	logic signed [ACCEL_W:0] on_e;
	logic signed [ACCEL_W:0] off_e;

	assign tilt_e = {tilt[ACCEL_W-1], tilt};
	assign on_e   = $signed({2'b00, on_thr});
	assign off_e  = $signed({2'b00, off_thr});

	// release first, then engage negative, then engage positive
	always_comb begin
		dir_nxt = dir_q;
		case (dir_q)
			DIR_NEG: begin
				if (tilt_e >= -off_e) dir_nxt = DIR_NONE;
			end
			DIR_POS: begin
				if (tilt_e <= off_e) dir_nxt = DIR_NONE;
			end
			default: dir_nxt = dir_q;
		endcase
		if (tilt_e <= -on_e) dir_nxt = DIR_NEG;
		if (tilt_e >= on_e)  dir_nxt = DIR_POS;
		if (!update)         dir_nxt = dir_q;
	end

	// press is reported only on a change of direction
	assign res.held  = dir_nxt;
	assign res.press = (dir_nxt != dir_q) ? dir_nxt : DIR_NONE;

	// direction state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= DIR_NONE;
		end else begin
			dir_q <= dir_nxt;
		end
	end

endmodule

// ===== hdl/tdpc_cal.sv =====
// face-up offset calibrator: averages stable samples, emits corrected bytes
module tdpc_cal #(
	parameter int CAL_SAMPLES = tdpc_pkg::CAL_SAMPLES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                update,
	input  logic signed [tdpc_pkg::ACCEL_W-1:0] x,
	input  logic signed [tdpc_pkg::ACCEL_W-1:0] y,
	input  logic signed [tdpc_pkg::ACCEL_W-1:0] z,
	input  tdpc_pkg::cfg_t                      cfg,
	output tdpc_pkg::cal_res_t                  res
);
	import tdpc_pkg::*;

	// sum / (4 * CAL_SAMPLES) by reciprocal multiply, exact for 16 bit magnitudes
	localparam int DIV     = CAL_SAMPLES * 4;
	localparam int SHIFT   = 24;
	localparam int RECIP_W = 24;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(((1 << SHIFT) + DIV - 1) / DIV);
	localparam int CNT_W   = $clog2(CAL_SAMPLES + 1);
	localparam logic [CNT_W-1:0] CNT_DONE = CNT_W'(CAL_SAMPLES);

	logic                       cal_q;
	logic signed [ACCEL_W-1:0]  prev_x_q, prev_y_q, prev_z_q;
	logic [SUM_W-1:0]           sum_x_q, sum_y_q, sum_z_q;
	logic [CNT_W-1:0]           cnt_q;

	logic signed [ACCEL_W:0]    dx, dy, dz;
	logic [ACCEL_W:0]           ax, ay, az;
	logic [TOL_W-1:0]           diff_sum;
	logic signed [ACCEL_W:0]    z_e;
	logic signed [ACCEL_W:0]    neg_half;
	logic signed [ACCEL_W:0]    z_corr;
	logic                       face_up;
	logic                       stable;
	logic                       good;
	logic                       run;
	logic                       done;
	logic [SUM_W-1:0]           sum_x_nxt, sum_y_nxt, sum_z_nxt;
	logic [CNT_W-1:0]           cnt_inc;

	// stored byte minus truncated average, modulo 256
	function automatic logic [OFFSET_W-1:0] fix_byte(input logic [OFFSET_W-1:0] stored,
			input logic [SUM_W-1:0] sum);
		logic              neg;
		logic [SUM_W-1:0]  mag;
		logic [PROD_W-1:0] prod;
		logic [OFFSET_W-1:0] q;
		neg  = sum[SUM_W-1];
		mag  = neg ? (~sum + SUM_W'(1)) : sum;
		prod = PROD_W'(mag) * PROD_W'(RECIP);
		q    = prod[SHIFT +: OFFSET_W];
		if (neg) q = ~q + OFFSET_W'(1);
		return stored - q;
	endfunction

	// stability: summed absolute change against the previous sample
	assign dx = {x[ACCEL_W-1], x} - {prev_x_q[ACCEL_W-1], prev_x_q};
	assign dy = {y[ACCEL_W-1], y} - {prev_y_q[ACCEL_W-1], prev_y_q};
	assign dz = {z[ACCEL_W-1], z} - {prev_z_q[ACCEL_W-1], prev_z_q};
	assign ax = dx[ACCEL_W] ? 11'(-dx) : 11'(dx);
	assign ay = dy[ACCEL_W] ? 11'(-dy) : 11'(dy);
	assign az = dz[ACCEL_W] ? 11'(-dz) : 11'(dz);
	assign diff_sum = TOL_W'(ax) + TOL_W'(ay) + TOL_W'(az);
	assign stable   = diff_sum < cfg.tol;

	// face-up test against half of one g
	assign z_e      = {z[ACCEL_W-1], z};
	assign neg_half = -$signed({3'b000, cfg.one_g[THR_W-1:1]});
	assign face_up  = z_e < neg_half;
	assign z_corr   = z_e + $signed({2'b00, cfg.one_g});

	assign run  = update && !cal_q;
	assign good = face_up && stable;

	// running sums, wrapping at 16 bits
	assign sum_x_nxt = sum_x_q + SUM_W'(x);
	assign sum_y_nxt = sum_y_q + SUM_W'(y);
	assign sum_z_nxt = sum_z_q + SUM_W'(z_corr);
	assign cnt_inc   = cnt_q + CNT_W'(1);
	assign done      = run && good && (cnt_inc >= CNT_DONE);

	// result for the item in flight
	always_comb begin
		res = '0;
		res.calibrated = cal_q || done;
		res.ready      = done;
		if (done) begin
			res.offset_x = fix_byte(cfg.offset_x, sum_x_nxt);
			res.offset_y = fix_byte(cfg.offset_y, sum_y_nxt);
			res.offset_z = fix_byte(cfg.offset_z, sum_z_nxt);
		end
	end

	// calibrator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q    <= 1'b0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			prev_z_q <= '0;
			sum_x_q  <= '0;
			sum_y_q  <= '0;
			sum_z_q  <= '0;
			cnt_q    <= '0;
		end else if (run) begin
			prev_x_q <= x;
			prev_y_q <= y;
			prev_z_q <= z;
			if (good) begin
				sum_x_q <= sum_x_nxt;
				sum_y_q <= sum_y_nxt;
				sum_z_q <= sum_z_nxt;
				cnt_q   <= cnt_inc;
				if (done) cal_q <= 1'b1;
			end else begin
				sum_x_q <= '0;
				sum_y_q <= '0;
				sum_z_q <= '0;
				cnt_q   <= '0;
			end
		end
	end

endmodule

// ===== hdl/tilt_dpad_with_calibration.sv =====
// Tilt pad with hysteresis and one-shot face-up offset calibration.
// Path: an accepted input item goes to the input register, then on to the result register
// once the result slot frees. Throughput: one item per cycle unless m_tready stalls results;
// the item step is a single pass of logic between the two registers.
// Reset: arst_n clears directions, calibration sums, count and flag, both stages,
// and returns the configuration registers to their defaults.
module tilt_dpad_with_calibration #(
	parameter int CAL_SAMPLES = tdpc_pkg::CAL_SAMPLES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_we,
	input  logic [tdpc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [tdpc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	// input items
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [tdpc_pkg::S_TDATA_W-1:0]      s_tdata,  // accel_x, accel_y, accel_z, zero fill
	input  logic                                s_tuser,  // sample_valid
	// result items
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// press_h, press_v, held_h, held_v, is_calibrated, offsets_ready,
	// new_offset_x, new_offset_y, new_offset_z, zero fill
	output logic [tdpc_pkg::M_TDATA_W-1:0]      m_tdata
);
	import tdpc_pkg::*;

	cfg_t                      cfg_q;

	logic                      in_valid_s1;
	logic                      flag_s1;
	logic signed [ACCEL_W-1:0] x_s1, y_s1, z_s1;

	logic                      out_valid_s2;
	logic [M_TDATA_W-1:0]      data_s2;

	logic                      advance;
	logic                      update;
	axis_res_t                 res_h, res_v;
	cal_res_t                  res_cal;
	logic [M_TDATA_W-1:0]      data_nxt;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_thr   <= ON_THR_RST;
			cfg_q.off_thr  <= OFF_THR_RST;
			cfg_q.one_g    <= ONE_G_RST;
			cfg_q.tol      <= TOL_RST;
			cfg_q.offset_x <= OFFSET_RST;
			cfg_q.offset_y <= OFFSET_RST;
			cfg_q.offset_z <= OFFSET_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				REG_ON_THR:   cfg_q.on_thr   <= cfg_wdata[THR_W-1:0];
				REG_OFF_THR:  cfg_q.off_thr  <= cfg_wdata[THR_W-1:0];
				REG_ONE_G:    cfg_q.one_g    <= cfg_wdata[THR_W-1:0];
				REG_TOL:      cfg_q.tol      <= cfg_wdata[TOL_W-1:0];
				REG_OFFSET_X: cfg_q.offset_x <= cfg_wdata[OFFSET_W-1:0];
				REG_OFFSET_Y: cfg_q.offset_y <= cfg_wdata[OFFSET_W-1:0];
				REG_OFFSET_Z: cfg_q.offset_z <= cfg_wdata[OFFSET_W-1:0];
				default: ;
			endcase
		end
	end

	// handshake: the item in the input register moves on when the result slot frees
	assign advance  = in_valid_s1 && (!out_valid_s2 || m_tready);
	assign s_tready = !in_valid_s1 || advance;
	assign update   = advance && flag_s1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			flag_s1 <= s_tuser;
			x_s1    <= s_tdata[ACCEL_W-1:0];
			y_s1    <= s_tdata[2*ACCEL_W-1:ACCEL_W];
			z_s1    <= s_tdata[3*ACCEL_W-1:2*ACCEL_W];
		end
	end

	// horizontal axis follows y, vertical axis follows x
	tdpc_axis u_axis_h (
		.clk     (clk),
		.arst_n  (arst_n),
		.update  (update),
		.tilt    (y_s1),
		.on_thr  (cfg_q.on_thr),
		.off_thr (cfg_q.off_thr),
		.res     (res_h)
	);

	tdpc_axis u_axis_v (
		.clk     (clk),
		.arst_n  (arst_n),
		.update  (update),
		.tilt    (x_s1),
		.on_thr  (cfg_q.on_thr),
		.off_thr (cfg_q.off_thr),
		.res     (res_v)
	);

	// offset calibrator
	tdpc_cal #(
		.CAL_SAMPLES (CAL_SAMPLES)
	) u_cal (
		.clk    (clk),
		.arst_n (arst_n),
		.update (update),
		.x      (x_s1),
		.y      (y_s1),
		.z      (z_s1),
		.cfg    (cfg_q),
		.res    (res_cal)
	);

	// pack the result item
	assign data_nxt = M_TDATA_W'({res_cal.offset_z, res_cal.offset_y, res_cal.offset_x,
		res_cal.ready, res_cal.calibrated,
		res_v.held, res_h.held, res_v.press, res_h.press});

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (m_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= data_nxt;
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata  = data_s2;

endmodule

// ===== dv/tdpc_checker.sv =====
// result predictor and comparator for the tilt pad with calibration
module tdpc_checker
	import tdpc_pkg::*;
#(
	parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,  // accel_x, accel_y, accel_z, zero fill
	input  logic                  s_tuser,  // sample_valid
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	// press_h, press_v, held_h, held_v, is_calibrated, offsets_ready,
	// new_offset_x, new_offset_y, new_offset_z, zero fill
	input  logic [M_TDATA_W-1:0]  m_tdata,
	output int                    errors,
	output int                    pending,
	output int                    checked,
	output int                    cal_events
);
	timeunit 1ns;
	timeprecision 1ps;

	// one predicted result item
	typedef struct packed {
		dir_t                press_h;
		dir_t                press_v;
		dir_t                held_h;
		dir_t                held_v;
		logic                calibrated;
		logic                ready;
		logic [OFFSET_W-1:0] ox;
		logic [OFFSET_W-1:0] oy;
		logic [OFFSET_W-1:0] oz;
	} pad_result_t;

	// shadow of the register file and the pad state
	cfg_t                       regs;
	dir_t                       dir_h, dir_v;
	logic                       cal_done;
	logic signed [ACCEL_W-1:0]  last_x, last_y, last_z;
	logic [SUM_W-1:0]           acc_x, acc_y, acc_z;
	int                         run_len;
	pad_result_t                expected_q[$];
	pad_result_t                want;

	function automatic int mag_of(int v);
		return (v < 0) ? -v : v;
	endfunction

	// hysteresis: release first, then negative engage, then positive engage
	function automatic dir_t axis_next(dir_t last, int tilt);
		int   on_lvl;
		int   off_lvl;
		dir_t cur;
		on_lvl  = int'(regs.on_thr);
		off_lvl = int'(regs.off_thr);
		cur     = last;
		if ((last == DIR_NEG && tilt >= -off_lvl) || (last == DIR_POS && tilt <= off_lvl))
			cur = DIR_NONE;
		if (tilt <= -on_lvl)
			cur = DIR_NEG;
		if (tilt >= on_lvl)
			cur = DIR_POS;
		return cur;
	endfunction

	// stored byte minus the averaged sum, truncated toward zero, byte wrap
	function automatic logic [OFFSET_W-1:0] corrected(logic [OFFSET_W-1:0] stored,
			logic [SUM_W-1:0] acc);
		int q;
		q = int'($signed(acc)) / (CAL_SAMPLES * 4);
		return OFFSET_W'(int'(stored) - q);
	endfunction

	// advance the shadow state by one input item and return its result
	function automatic pad_result_t predict_step(logic valid, logic signed [ACCEL_W-1:0] x,
			logic signed [ACCEL_W-1:0] y, logic signed [ACCEL_W-1:0] z);
		pad_result_t r;
		dir_t        old_h;
		dir_t        old_v;
		int          half;
		int          diff;
		r     = '0;
		old_h = dir_h;
		old_v = dir_v;
		if (valid) begin
			// calibrator runs only until it has completed once
			if (!cal_done) begin
				half = int'(regs.one_g >> 1);
				diff = mag_of(int'(x) - int'(last_x)) + mag_of(int'(y) - int'(last_y))
					+ mag_of(int'(z) - int'(last_z));
				if (int'(z) < -half && diff < int'(regs.tol)) begin
					acc_x = acc_x + SUM_W'(int'(x));
					acc_y = acc_y + SUM_W'(int'(y));
					acc_z = acc_z + SUM_W'(int'(z) + int'(regs.one_g));
					run_len++;
					if (run_len >= CAL_SAMPLES) begin
						r.ready  = 1'b1;
						r.ox     = corrected(regs.offset_x, acc_x);
						r.oy     = corrected(regs.offset_y, acc_y);
						r.oz     = corrected(regs.offset_z, acc_z);
						cal_done = 1'b1;
					end
				end else begin
					acc_x   = '0;
					acc_y   = '0;
					acc_z   = '0;
					run_len = 0;
				end
				last_x = x;
				last_y = y;
				last_z = z;
			end
			// horizontal follows y, vertical follows x
			dir_h = axis_next(old_h, int'(y));
			dir_v = axis_next(old_v, int'(x));
		end
		r.press_h    = (dir_h != old_h) ? dir_h : DIR_NONE;
		r.press_v    = (dir_v != old_v) ? dir_v : DIR_NONE;
		r.held_h     = dir_h;
		r.held_v     = dir_v;
		r.calibrated = cal_done;
		return r;
	endfunction

	function automatic void check_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
		if (exp_val !== act_val) begin
			errors++;
			$display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
				$time, name, exp_val, act_val);
		end
	endfunction

	// watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = '{on_thr: ON_THR_RST, off_thr: OFF_THR_RST, one_g: ONE_G_RST, tol: TOL_RST,
				offset_x: OFFSET_RST, offset_y: OFFSET_RST, offset_z: OFFSET_RST};
			dir_h      = DIR_NONE;
			dir_v      = DIR_NONE;
			cal_done   = 1'b0;
			last_x     = '0;
			last_y     = '0;
			last_z     = '0;
			acc_x      = '0;
			acc_y      = '0;
			acc_z      = '0;
			run_len    = 0;
			errors     = 0;
			checked    = 0;
			cal_events = 0;
			expected_q.delete();
			pending    = 0;
		end else begin
			// register writes, unknown indexes fall through
			if (cfg_we) begin
				case (cfg_index)
					REG_ON_THR:   regs.on_thr   = cfg_wdata[THR_W-1:0];
					REG_OFF_THR:  regs.off_thr  = cfg_wdata[THR_W-1:0];
					REG_ONE_G:    regs.one_g    = cfg_wdata[THR_W-1:0];
					REG_TOL:      regs.tol      = cfg_wdata[TOL_W-1:0];
					REG_OFFSET_X: regs.offset_x = cfg_wdata[OFFSET_W-1:0];
					REG_OFFSET_Y: regs.offset_y = cfg_wdata[OFFSET_W-1:0];
					REG_OFFSET_Z: regs.offset_z = cfg_wdata[OFFSET_W-1:0];
					default: ;
				endcase
			end
			// compare the result item against the oldest prediction
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					errors++;
					$display("%0t ns: result item with nothing expected, actual 0x%0h",
						$time, m_tdata);
				end else begin
					want = expected_q.pop_front();
					check_field("press_h", 8'(want.press_h), 8'(m_tdata[1:0]));
					check_field("press_v", 8'(want.press_v), 8'(m_tdata[3:2]));
					check_field("held_h", 8'(want.held_h), 8'(m_tdata[5:4]));
					check_field("held_v", 8'(want.held_v), 8'(m_tdata[7:6]));
					check_field("is_calibrated", 8'(want.calibrated), 8'(m_tdata[8]));
					check_field("offsets_ready", 8'(want.ready), 8'(m_tdata[9]));
					check_field("new_offset_x", want.ox, m_tdata[17:10]);
					check_field("new_offset_y", want.oy, m_tdata[25:18]);
					check_field("new_offset_z", want.oz, m_tdata[33:26]);
					checked++;
					if (want.ready)
						cal_events++;
				end
			end
			// predict the accepted input item
			if (s_tvalid && s_tready)
				expected_q.push_back(predict_step(s_tuser, s_tdata[ACCEL_W-1:0],
					s_tdata[2*ACCEL_W-1:ACCEL_W], s_tdata[3*ACCEL_W-1:2*ACCEL_W]));
			pending = expected_q.size();
		end
	end

endmodule

// ===== dv/tilt_dpad_with_calibration_tb.sv =====
// stimulus and verdict for the tilt pad with calibration
module tilt_dpad_with_calibration_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tdpc_pkg::*;

	// write to an index past the register list, must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
	localparam int STALL_LIMIT = 2000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;  // accel_x, accel_y, accel_z, zero fill
	logic                  s_tuser;  // sample_valid
	logic                  m_tvalid;
	logic                  m_tready;
	// press_h, press_v, held_h, held_v, is_calibrated, offsets_ready,
	// new_offset_x, new_offset_y, new_offset_z, zero fill
	logic [M_TDATA_W-1:0]  m_tdata;

	int errors, pending, checked, cal_events;

	// generator view of the current settings
	int cur_on, cur_off, cur_one_g, cur_tol;
	bit calm;
	bit after_jump;
	int sent_total, sent_valid;
	int run_x, run_y, run_z;
	int idle_cycles;

	tilt_dpad_with_calibration uut (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_wdata,
		.s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata
	);

	tdpc_checker u_checker (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_wdata,
		.s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata,
		.errors, .pending, .checked, .cal_events
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int clip(int v, int lo, int hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic int rand10();
		return int'($urandom_range(0, 1023)) - 512;
	endfunction

	// bursts with no idling come and go with calm
	function automatic int idle_draw();
		return calm ? 0 : int'($urandom_range(0, 9));
	endfunction

	// highest z that still counts as face-up
	function automatic int face_up_top();
		return -(cur_one_g / 2) - 1;
	endfunction

	// tilt near a threshold, around zero, or anywhere
	function automatic int pick_tilt();
		int base;
		int v;
		case ($urandom_range(0, 3))
			0: return rand10();
			1: base = cur_on;
			2: base = cur_off;
			default: base = 0;
		endcase
		v = base + int'($urandom_range(0, 6)) - 3;
		if ($urandom_range(0, 1))
			v = -v;
		return clip(v, -512, 511);
	endfunction

	// offer one sample item and wait for its acceptance
	task automatic push_sample(bit valid, int x, int y, int z);
		int gap;
		gap = idle_draw();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= valid;
		s_tdata  <= {2'b00, 10'(z), 10'(y), 10'(x)};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent_total++;
		if (valid)
			sent_valid++;
		if ($urandom_range(0, 39) == 0)
			calm = !calm;
	endtask

	task automatic push_noise();
		push_sample(1'b0, rand10(), rand10(), rand10());
	endtask

	// stop offering items and wait until every result is back
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	// rewrite every register, plus one write to an unused index
	task automatic load_settings(int on, int off, int g, int tol, int ox, int oy, int oz);
		logic [CFG_IDX_W-1:0]  idx [8];
		logic [CFG_DATA_W-1:0] val [8];
		drain();
		idx = '{REG_ON_THR, REG_OFF_THR, REG_ONE_G, REG_TOL,
			REG_OFFSET_X, REG_OFFSET_Y, REG_OFFSET_Z, REG_SPARE};
		// unused upper bits carry junk
		val[0] = {3'($urandom), 9'(on)};
		val[1] = {3'($urandom), 9'(off)};
		val[2] = {3'($urandom), 9'(g)};
		val[3] = 12'(tol);
		val[4] = {4'($urandom), 8'(ox)};
		val[5] = {4'($urandom), 8'(oy)};
		val[6] = {4'($urandom), 8'(oz)};
		val[7] = 12'($urandom);
		for (int i = 0; i < 8; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_wdata <= val[i];
			@(posedge clk);
		end
		cfg_we    <= 1'b0;
		cur_on    = on;
		cur_off   = off;
		cur_one_g = g;
		cur_tol   = tol;
	endtask

	// stable face-up runs with jitter, broken by a jump or a face-down sample;
	// without finish_cal a run never reaches the calibration count
	task automatic run_sequences(int quota, bit finish_cal);
		int start;
		int m;
		int j;
		start = sent_valid;
		while (sent_valid - start < quota) begin
			run_x = rand10();
			run_y = rand10();
			run_z = int'($urandom_range(0, face_up_top() + 512)) - 512;
			m = finish_cal ? 40 : int'($urandom_range(1, 12));
			j = (cur_tol > 0) ? (cur_tol - 1) / 3 : 0;
			if (j > 40)
				j = 40;
			repeat (m) begin
				if ($urandom_range(0, 5) == 0)
					push_noise();
				push_sample(1'b1, run_x, run_y, run_z);
				run_x = clip(run_x + int'($urandom_range(0, 2 * j)) - j, -512, 511);
				run_y = clip(run_y + int'($urandom_range(0, 2 * j)) - j, -512, 511);
				run_z = clip(run_z + int'($urandom_range(0, 2 * j)) - j, -512, face_up_top());
			end
			if (!finish_cal) begin
				// a jump is always followed by a face-down break next time
				if (!after_jump && $urandom_range(0, 2) == 0) begin
					push_sample(1'b1, rand10(), rand10(),
						int'($urandom_range(0, face_up_top() + 512)) - 512);
					after_jump = 1'b1;
				end else begin
					push_sample(1'b1, rand10(), rand10(),
						int'($urandom_range(0, 511 + cur_one_g / 2)) - cur_one_g / 2);
					after_jump = 1'b0;
				end
			end
		end
	endtask

	// direction work around the thresholds
	task automatic tilt_phase(int quota);
		int start;
		start = sent_valid;
		while (sent_valid - start < quota) begin
			if ($urandom_range(0, 7) == 0)
				push_noise();
			push_sample(1'b1, pick_tilt(), pick_tilt(), rand10());
		end
	endtask

	// result side: random stalls per item
	initial begin
		int stall;
		m_tready <= 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			stall = idle_draw();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	// stimulus sequence and verdict
	initial begin
		s_tvalid   <= 1'b0;
		s_tdata    <= '0;
		s_tuser    <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_index  <= '0;
		cfg_wdata  <= '0;
		calm        = 1'b0;
		after_jump  = 1'b0;
		sent_total  = 0;
		sent_valid  = 0;
		cur_on      = int'(ON_THR_RST);
		cur_off     = int'(OFF_THR_RST);
		cur_one_g   = int'(ONE_G_RST);
		cur_tol     = int'(TOL_RST);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed items on reset settings
		push_sample(1'b0, 511, -512, -512);   // ignored sample
		push_sample(1'b1, 0, 0, 0);
		push_sample(1'b1, -80, 80, 0);        // both axes engage at the threshold
		push_sample(1'b1, -79, 79, 0);        // held
		push_sample(1'b1, -31, 31, 0);        // still held above release
		push_sample(1'b1, -30, 30, 0);        // release at the off threshold
		push_sample(1'b1, 511, -512, 511);    // extremes
		push_sample(1'b1, -512, 511, -1);     // straight reversal
		push_sample(1'b0, 0, 0, 0);           // ignored, directions kept
		push_sample(1'b1, 0, 0, -200);        // face-up but unstable
		push_sample(1'b1, 0, 0, -200);        // first stable sample
		push_sample(1'b1, 3, -3, -205);
		push_sample(1'b1, 3, -3, -129);       // too large a step
		push_sample(1'b1, 3, -3, -129);       // just face-up
		push_sample(1'b1, 3, -3, -128);       // on the face-up limit, clears
		push_sample(1'b1, -1, -1, -1);
		push_sample(1'b1, -512, -512, -512);

		// calibrator runs that never complete, several settings
		load_settings(80, 30, 256, 16, 8'h12, 8'h34, 8'h56);
		run_sequences(150, 1'b0);
		load_settings(0, 511, 0, 3071, 8'hff, 8'hff, 8'hff);
		run_sequences(120, 1'b0);
		load_settings(511, 0, 511, 0, 0, 0, 0);
		tilt_phase(120);
		load_settings(200, 200, 300, 100, 8'ha5, 8'h5a, 8'h80);
		run_sequences(150, 1'b0);
		cur_on = int'($urandom_range(20, 300));
		load_settings(cur_on, int'($urandom_range(0, cur_on)), int'($urandom_range(0, 511)),
			int'($urandom_range(1, 3071)), int'($urandom_range(0, 255)),
			int'($urandom_range(0, 255)), int'($urandom_range(0, 255)));
		run_sequences(150, 1'b0);

		// one run long enough to finish calibration
		load_settings(80, 30, 256, 3071, 8'hff, 8'h00, 8'h80);
		run_sequences(40, 1'b1);

		// calibrated, directions only
		load_settings(0, 0, 0, 0, 0, 0, 0);
		tilt_phase(110);
		load_settings(511, 511, 511, 3071, 8'hff, 8'hff, 8'hff);
		tilt_phase(110);
		cur_on = int'($urandom_range(1, 511));
		load_settings(cur_on, int'($urandom_range(0, 511)), int'($urandom_range(0, 511)),
			int'($urandom_range(0, 3071)), int'($urandom_range(0, 255)),
			int'($urandom_range(0, 255)), int'($urandom_range(0, 255)));
		tilt_phase(110);

		drain();
		repeat (4) @(posedge clk);
		$display("sent %0d sample items (%0d marked valid), compared %0d results",
			sent_total, sent_valid, checked);
		$display("nine register settings, calibration completed %0d time(s), %0d mismatches",
			cal_events, errors);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
